@@ sv/sawtc_pkg.sv @@
// shared constants, codes and types of the set-associative write-through cache
`timescale 1ns / 1ps
`default_nettype none

package sawtc_pkg;

	localparam int AddrW = 32;
	localparam int DataW = 32;
	localparam int LenW  = 3;
	localparam int TypeW = 2;
	localparam int SeedW = 16;

	localparam int LineBytesDef = 64;
	localparam int NumSetsDef   = 128;
	localparam int NumWaysDef   = 8;
	localparam int AddrBitsDef  = 32;

	localparam logic [SeedW-1:0] SeedReset = 16'd44257;
	localparam logic [SeedW-1:0] LfsrTaps  = 16'hB400;

	typedef enum logic [TypeW-1:0] {
		ReqRead  = 2'd0,
		ReqWrite = 2'd1,
		ReqFill  = 2'd2
	} req_type_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_FREAD,
		ST_FRESP
	} state_t;

	typedef struct packed {
		logic             hit;
		logic             read_valid;
		logic [DataW-1:0] rdata;
		logic             fill_request;
		logic             mem_write;
		logic [AddrW-1:0] mem_addr;
		logic [LenW-1:0]  mem_len;
		logic [DataW-1:0] mem_data;
	} rsp_t;

endpackage

`default_nettype wire

@@ sv/sawtc_ifs.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface sawtc_req_if import sawtc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [TypeW-1:0] req_type;
	logic [AddrW-1:0] addr;
	logic [LenW-1:0]  len;
	logic [DataW-1:0] wdata;
	logic [DataW-1:0] fill_data;
	logic             fill_last;

	modport source (output valid, req_type, addr, len, wdata, fill_data, fill_last,
		input ready);
	modport sink (input valid, req_type, addr, len, wdata, fill_data, fill_last,
		output ready);
endinterface

interface sawtc_rsp_if import sawtc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             hit;
	logic             read_valid;
	logic [DataW-1:0] rdata;
	logic             fill_request;
	logic             mem_write;
	logic [AddrW-1:0] mem_addr;
	logic [LenW-1:0]  mem_len;
	logic [DataW-1:0] mem_data;

	modport source (output valid, hit, read_valid, rdata, fill_request, mem_write,
		mem_addr, mem_len, mem_data, input ready);
	modport sink (input valid, hit, read_valid, rdata, fill_request, mem_write,
		mem_addr, mem_len, mem_data, output ready);
endinterface

`default_nettype wire

@@ sv/sawtc_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sawtc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/set_assoc_write_through_cache.sv @@
// set-associative write-through cache, no write-allocate, lfsr replacement
//
// channels: req (sink) takes reads, writes and line fill words; rsp (source)
// gives exactly one result transfer per request transfer, in order.
// cfg_we/cfg_wdata reload the replacement lfsr (zero loads one); write only
// while idle.
// timing: a request is taken in the idle cycle, the tag row and the two data
// words it touches are read from synchronous memory, and the exec state that
// follows compares tags, writes back and loads the result register. so reads,
// writes and plain fill words are handled one at a time: the next request is
// taken only after the read-modify-write, which waits on the registered read
// of the tag and data memories. the last fill word goes on through fread and
// fresp: after the line is written the pending read goes to the data memory again.
// reset: the tag memory is swept one set per cycle to clear all valid bits,
// during which req.ready stays low.
// stalls: the result register holds a finished result while rsp.ready is
// low; the next request is still taken and waits in its compare cycle.
// accesses must not cross a line; bytes past the line end read as zero.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_write_through_cache
	import sawtc_pkg::*;
#(
	parameter int LINE_BYTES = LineBytesDef,
	parameter int NUM_SETS   = NumSetsDef,
	parameter int NUM_WAYS   = NumWaysDef,
	parameter int ADDR_BITS  = AddrBitsDef
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [SeedW-1:0] cfg_wdata,
	sawtc_req_if.sink             req,
	sawtc_rsp_if.source           rsp
);

	// address split
	localparam int OFF_W    = $clog2(LINE_BYTES);
	localparam int SET_W    = $clog2(NUM_SETS);
	localparam int SET_IW   = (SET_W > 0) ? SET_W : 1;
	localparam int AW       = (ADDR_BITS < AddrW) ? ADDR_BITS : AddrW;
	localparam int TAG_W    = AW - OFF_W - SET_W;
	localparam int WORDS    = LINE_BYTES / 4;
	localparam int HALF     = WORDS / 2;
	localparam int WI_W     = $clog2(WORDS);
	localparam int HI_W     = (HALF > 1) ? $clog2(HALF) : 1;
	localparam int BK_DEPTH = NUM_SETS * HALF;
	localparam int BK_AW    = (BK_DEPTH > 1) ? $clog2(BK_DEPTH) : 1;
	localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int TROW_W   = NUM_WAYS * (TAG_W + 1);
	localparam int DROW_W   = NUM_WAYS * DataW;

	localparam logic [AddrW-1:0] AddrMask =
		(AW >= AddrW) ? '1 : AddrW'((64'd1 << AW) - 64'd1);
	localparam logic [AddrW-1:0] LineMask = ~AddrW'(LINE_BYTES - 1);

	// byte mask of an access length, len already in 1..4
	function automatic logic [3:0] byte_mask(input logic [LenW-1:0] n);
		logic [3:0] m;
		m = (n >= 3'd4) ? 4'hF : 4'((5'd1 << n) - 5'd1);
		return m;
	endfunction

	function automatic logic [DataW-1:0] expand(input logic [3:0] m);
		logic [DataW-1:0] r;
		for (int k = 0; k < 4; k++) begin
			r[8*k +: 8] = {8{m[k]}};
		end
		return r;
	endfunction

	function automatic logic [LenW-1:0] fix_len(input logic [LenW-1:0] n);
		logic [LenW-1:0] r;
		r = n;
		if (n == '0) begin
			r = 3'd1;
		end else if (n > 3'd4) begin
			r = 3'd4;
		end
		return r;
	endfunction

	function automatic logic [SET_IW-1:0] set_of(input logic [AddrW-1:0] a);
		return SET_IW'((a >> OFF_W) & AddrW'(NUM_SETS - 1));
	endfunction

	function automatic logic [TAG_W-1:0] tag_of(input logic [AddrW-1:0] a);
		return TAG_W'(a >> (OFF_W + SET_W));
	endfunction

	function automatic logic [WI_W-1:0] word_of(input logic [AddrW-1:0] a);
		return WI_W'((a & AddrW'(LINE_BYTES - 1)) >> 2);
	endfunction

	// even bank holds even words of a line, odd bank odd words
	function automatic logic [BK_AW-1:0] even_addr(input logic [SET_IW-1:0] s,
		input logic [WI_W-1:0] wi);
		logic [HI_W-1:0] h;
		h = HI_W'(((32'(wi) >> 1) + 32'(wi[0])) & 32'(HALF - 1));
		return BK_AW'(32'(s) * HALF + 32'(h));
	endfunction

	function automatic logic [BK_AW-1:0] odd_addr(input logic [SET_IW-1:0] s,
		input logic [WI_W-1:0] wi);
		logic [HI_W-1:0] h;
		h = HI_W'((32'(wi) >> 1) & 32'(HALF - 1));
		return BK_AW'(32'(s) * HALF + 32'(h));
	endfunction

	// little-endian extract of n bytes at word wi, byte b0, from one way
	function automatic logic [DataW-1:0] pick(input logic [DROW_W-1:0] erow,
		input logic [DROW_W-1:0] orow, input logic [WAY_W-1:0] way,
		input logic [WI_W-1:0] wi, input logic [1:0] b0, input logic [LenW-1:0] n);
		logic [DataW-1:0]   lo;
		logic [DataW-1:0]   hi;
		logic [2*DataW-1:0] cat;
		lo = wi[0] ? orow[32'(way)*DataW +: DataW] : erow[32'(way)*DataW +: DataW];
		hi = wi[0] ? erow[32'(way)*DataW +: DataW] : orow[32'(way)*DataW +: DataW];
		if (wi == WI_W'(WORDS - 1)) begin
			hi = '0;
		end
		cat = {hi, lo} >> (8 * b0);
		return cat[DataW-1:0] & expand(byte_mask(n));
	endfunction

	state_t state_q, state_d;
	logic [SET_IW-1:0] clr_q;

	// request captured at transfer
	logic [TypeW-1:0] type_s1;
	logic [AddrW-1:0] addr_s1;
	logic [LenW-1:0]  len_s1;
	logic [DataW-1:0] wdata_s1;
	logic [DataW-1:0] fdata_s1;
	logic             last_s1;
	logic [BK_AW-1:0] ev_addr_s1;
	logic [BK_AW-1:0] od_addr_s1;

	// pending miss and replacement state
	logic [AddrW-1:0] pend_addr_q;
	logic [LenW-1:0]  pend_len_q;
	logic [WAY_W-1:0] victim_q;
	logic [SeedW-1:0] lfsr_q;

	logic out_v_q;
	rsp_t out_q;

	logic             accept;
	logic [AddrW-1:0] in_a;
	logic [SET_IW-1:0] in_set, p_set, s_set, rd_set, dset;
	logic [WI_W-1:0]  in_wi, p_wi, s_wi, dwi;
	logic [TAG_W-1:0] s_tag, p_tag;
	logic             data_re;
	logic [BK_AW-1:0] ev_ra, od_ra;

	logic              tag_we;
	logic [SET_IW-1:0] tag_wa;
	logic [TROW_W-1:0] tag_wd, tag_row;
	logic              ev_we, od_we;
	logic [DROW_W-1:0] ev_wd, od_wd, ev_row, od_row;

	logic [NUM_WAYS-1:0] valid_v, hit_vec;
	logic                any_hit, any_free, pend_ok, out_free;
	logic [WAY_W-1:0]    hit_way, free_way, victim;
	logic [2*DataW-1:0]  wr_data64;
	logic [7:0]          wr_en8;
	logic [3:0]          en_ev, en_od;
	logic [DataW-1:0]    dat_ev, dat_od;
	logic                hi_ok;

	rsp_t res;
	logic res_load, miss_upd, fill_done;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	assign in_a   = req.addr & AddrMask;
	assign in_set = set_of(in_a);
	assign in_wi  = word_of(in_a);
	assign p_set  = set_of(pend_addr_q);
	assign p_wi   = word_of(pend_addr_q);
	assign p_tag  = tag_of(pend_addr_q);
	assign s_set  = set_of(addr_s1);
	assign s_wi   = word_of(addr_s1);
	assign s_tag  = tag_of(addr_s1);

	// fill words land in the pending set; everything else uses its own set
	assign rd_set  = (req.req_type == ReqFill) ? p_set : in_set;
	assign dset    = (state_q == ST_FREAD) ? p_set : rd_set;
	assign dwi     = (state_q == ST_FREAD) ? p_wi : in_wi;
	assign data_re = accept || (state_q == ST_FREAD);
	assign ev_ra   = even_addr(dset, dwi);
	assign od_ra   = odd_addr(dset, dwi);

	// tag row: valid bits low, then one tag per way
	sawtc_ram #(.WIDTH(TROW_W), .DEPTH(NUM_SETS), .AW(SET_IW)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_wa),
		.wdata (tag_wd),
		.re    (accept),
		.raddr (rd_set),
		.rdata (tag_row)
	);

	sawtc_ram #(.WIDTH(DROW_W), .DEPTH(BK_DEPTH), .AW(BK_AW)) u_even_ram (
		.clk   (clk),
		.we    (ev_we),
		.waddr (ev_addr_s1),
		.wdata (ev_wd),
		.re    (data_re),
		.raddr (ev_ra),
		.rdata (ev_row)
	);

	sawtc_ram #(.WIDTH(DROW_W), .DEPTH(BK_DEPTH), .AW(BK_AW)) u_odd_ram (
		.clk   (clk),
		.we    (od_we),
		.waddr (od_addr_s1),
		.wdata (od_wd),
		.re    (data_re),
		.raddr (od_ra),
		.rdata (od_row)
	);

	// tag compare and way choice
	assign valid_v = tag_row[NUM_WAYS-1:0];

	always_comb begin
		hit_way  = '0;
		free_way = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			hit_vec[w] = valid_v[w] && (tag_row[NUM_WAYS + w*TAG_W +: TAG_W] == s_tag);
		end
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_way = WAY_W'(w);
			end
			if (!valid_v[w]) begin
				free_way = WAY_W'(w);
			end
		end
	end

	assign any_hit  = |hit_vec;
	assign any_free = ~&valid_v;
	assign victim   = any_free ? free_way : WAY_W'(lfsr_q & SeedW'(NUM_WAYS - 1));
	assign pend_ok  = (pend_len_q != '0);
	assign out_free = !out_v_q || rsp.ready;

	// write hit: shift bytes into the two-word window, split per bank
	assign wr_data64 = (2*DataW)'(wdata_s1) << (8 * addr_s1[1:0]);
	assign wr_en8    = 8'(byte_mask(len_s1)) << addr_s1[1:0];
	assign hi_ok     = (s_wi != WI_W'(WORDS - 1));
	assign en_ev     = s_wi[0] ? (wr_en8[7:4] & {4{hi_ok}}) : wr_en8[3:0];
	assign en_od     = s_wi[0] ? wr_en8[3:0] : (wr_en8[7:4] & {4{hi_ok}});
	assign dat_ev    = s_wi[0] ? wr_data64[2*DataW-1:DataW] : wr_data64[DataW-1:0];
	assign dat_od    = s_wi[0] ? wr_data64[DataW-1:0] : wr_data64[2*DataW-1:DataW];

	always_comb begin
		state_d   = state_q;
		tag_we    = 1'b0;
		tag_wa    = s_set;
		tag_wd    = tag_row;
		ev_we     = 1'b0;
		od_we     = 1'b0;
		ev_wd     = ev_row;
		od_wd     = od_row;
		res       = '0;
		res_load  = 1'b0;
		miss_upd  = 1'b0;
		fill_done = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				tag_we = 1'b1;
				tag_wa = clr_q;
				tag_wd = '0;
				if (clr_q == SET_IW'(NUM_SETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_d  = ST_IDLE;
					res_load = 1'b1;
					unique case (type_s1)
						ReqRead: begin
							if (any_hit) begin
								res.hit        = 1'b1;
								res.read_valid = 1'b1;
								res.rdata      = pick(ev_row, od_row, hit_way, s_wi,
									addr_s1[1:0], len_s1);
							end else begin
								// victim goes invalid until its last fill word
								miss_upd           = 1'b1;
								tag_we             = 1'b1;
								tag_wd[victim]     = 1'b0;
								res.fill_request   = 1'b1;
								res.mem_addr       = addr_s1 & LineMask;
							end
						end
						ReqWrite: begin
							if (any_hit) begin
								res.hit = 1'b1;
								ev_we   = 1'b1;
								od_we   = 1'b1;
								for (int k = 0; k < 4; k++) begin
									if (en_ev[k]) begin
										ev_wd[32'(hit_way)*DataW + 8*k +: 8] = dat_ev[8*k +: 8];
									end
									if (en_od[k]) begin
										od_wd[32'(hit_way)*DataW + 8*k +: 8] = dat_od[8*k +: 8];
									end
								end
							end
							res.mem_write = 1'b1;
							res.mem_addr  = addr_s1;
							res.mem_len   = len_s1;
							res.mem_data  = wdata_s1 & expand(byte_mask(len_s1));
						end
						ReqFill: begin
							if (pend_ok) begin
								if (s_wi[0]) begin
									od_we = 1'b1;
									od_wd[32'(victim_q)*DataW +: DataW] = fdata_s1;
								end else begin
									ev_we = 1'b1;
									ev_wd[32'(victim_q)*DataW +: DataW] = fdata_s1;
								end
								if (last_s1) begin
									// line complete: set tag and valid, then reread
									tag_we           = 1'b1;
									tag_wa           = p_set;
									tag_wd[victim_q] = 1'b1;
									tag_wd[NUM_WAYS + 32'(victim_q)*TAG_W +: TAG_W] = p_tag;
									res_load         = 1'b0;
									state_d          = ST_FREAD;
								end
							end
						end
						default: begin
							// unused request code gives an all-zero result
						end
					endcase
				end
			end
			ST_FREAD: begin
				state_d = ST_FRESP;
			end
			ST_FRESP: begin
				if (out_free) begin
					res.read_valid = 1'b1;
					res.rdata      = pick(ev_row, od_row, victim_q, p_wi,
						pend_addr_q[1:0], pend_len_q);
					res_load       = 1'b1;
					fill_done      = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pend_addr_q <= '0;
			pend_len_q  <= '0;
			victim_q    <= '0;
			lfsr_q      <= SeedReset;
			out_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				lfsr_q <= (cfg_wdata == '0) ? SeedW'(1) : cfg_wdata;
			end else if (miss_upd) begin
				lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LfsrTaps : '0);
			end
			if (miss_upd) begin
				pend_addr_q <= addr_s1;
				pend_len_q  <= len_s1;
				victim_q    <= victim;
			end else if (fill_done) begin
				pend_len_q <= '0;
			end
			if (res_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1    <= req.req_type;
			addr_s1    <= in_a;
			len_s1     <= fix_len(req.len);
			wdata_s1   <= req.wdata;
			fdata_s1   <= req.fill_data;
			last_s1    <= req.fill_last;
			ev_addr_s1 <= ev_ra;
			od_addr_s1 <= od_ra;
		end
		if (res_load) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.hit          = out_q.hit;
	assign rsp.read_valid   = out_q.read_valid;
	assign rsp.rdata        = out_q.rdata;
	assign rsp.fill_request = out_q.fill_request;
	assign rsp.mem_write    = out_q.mem_write;
	assign rsp.mem_addr     = out_q.mem_addr;
	assign rsp.mem_len      = out_q.mem_len;
	assign rsp.mem_data     = out_q.mem_data;

endmodule

`default_nettype wire
